FILE: design/fsg_pkg.sv
// ----------------------------------------------------------------------------
// fsg_pkg
// Shared types and constants for the formation setpoint generator.
// ----------------------------------------------------------------------------
package fsg_pkg;

  localparam int FOLLOWERS_DEF    = 5;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int OFFSET_REGS      = 5;

  localparam int POS_W  = 24;
  localparam int QUAT_W = 16;
  localparam int LA_W   = 12;
  localparam int OFS_W  = 48;
  localparam int CFG_IDX_W = 3;
  localparam int SAMPLE_W  = 6 * POS_W + 4 * QUAT_W;

  localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD = 3'd0;

  localparam logic [LA_W-1:0] LOOKAHEAD_RESET = 12'd256;
  localparam logic signed [31:0] KINV_Q30 = 32'sd652032874;
  localparam logic signed [POS_W-1:0] TGT_MAX = 24'sd8388607;
  localparam logic signed [POS_W-1:0] TGT_MIN = -24'sd8388608;

  function automatic logic [OFS_W-1:0] offset_reset(input int idx);
    case (idx)
      0: offset_reset = 48'hFC0000000000;
      1: offset_reset = 48'hFA0000000000;
      2: offset_reset = 48'hF80000000000;
      3: offset_reset = 48'hFE0000000000;
      4: offset_reset = 48'hF60000000000;
      default: offset_reset = '0;
    endcase
  endfunction

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture input sample
    logic pred;       // compute predicted position
    logic vec_init;   // start vectoring
    logic vec_step;   // one vectoring iteration
    logic rot_init;   // load follower offset
    logic rot_step;   // one rotation iteration
    logic gain_a;     // gain multiply x
    logic gain_b;     // gain multiply y
    logic fin;        // form result
  } fsg_cmd_t;

endpackage

FILE: design/fsg_if.sv
// ----------------------------------------------------------------------------
// fsg_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface fsg_if #(parameter int W = 8) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/fsg_datapath.sv
// ----------------------------------------------------------------------------
// fsg_datapath
// Prediction, shared CORDIC vectoring/rotation unit and output formatting.
// ----------------------------------------------------------------------------
module fsg_datapath #(
  parameter int CORDIC_STEPS = 16,
  parameter int STEP_W       = 5
) (
  input  logic                         clk,
  input  fsg_pkg::fsg_cmd_t            cmd,
  input  logic [STEP_W-1:0]            step,
  input  logic [fsg_pkg::SAMPLE_W-1:0] sample,
  input  logic [fsg_pkg::LA_W-1:0]     lookahead,
  input  logic [fsg_pkg::OFS_W-1:0]    offset,
  output logic [71:0]                  target
);
  import fsg_pkg::*;

  localparam int VW = 34;   // vectoring width, Q.28 with growth
  localparam int RW = 48;   // rotation width
  localparam int PW = 30;   // predicted position, v * lookahead >>> 8 reaches 2^27

  logic signed [POS_W-1:0] px_in, py_in, pz_in, vx, vy, vz;
  logic signed [QUAT_W-1:0] qx, qy, qz, qw;
  logic signed [PW-1:0] px, py, pz;
  logic signed [VW-1:0] num, den;
  logic zero, flip;
  logic [CORDIC_STEPS-1:0] cw;
  logic signed [RW-1:0] ox, oy;
  logic signed [15:0] offz;
  logic signed [63:0] prod;
  logic signed [25:0] rx, ry;

  logic signed [VW-1:0] ns, ds, num_i, den_i;
  logic signed [31:0] s1, s2;
  logic signed [POS_W+LA_W+1:0] mx, my, mz;

  assign ns = num >>> step;
  assign ds = den >>> step;
  assign s1 = 32'(qw) * 32'(qz) + 32'(qx) * 32'(qy);
  assign s2 = 32'(qy) * 32'(qy) + 32'(qz) * 32'(qz);
  assign num_i = VW'(s1) <<< 1;
  assign den_i = (VW'(1) <<< 28) - (VW'(s2) <<< 1);

  assign mx = (38'(vx) * $signed({1'b0, lookahead})) + 38'sd128;
  assign my = (38'(vy) * $signed({1'b0, lookahead})) + 38'sd128;
  assign mz = (38'(vz) * $signed({1'b0, lookahead})) + 38'sd128;

  function automatic logic signed [POS_W-1:0] sat(input logic signed [PW-1:0] v);
    if (v > PW'(TGT_MAX)) sat = TGT_MAX;
    else if (v < PW'(TGT_MIN)) sat = TGT_MIN;
    else sat = v[POS_W-1:0];
  endfunction

  logic signed [15:0] offx_w, offy_w;
  assign offx_w = offset[47:32];
  assign offy_w = offset[31:16];

  // rotated offsets stay below 2^29, so the low 32 bits carry the multiplier operand
  logic signed [31:0] ox_m, oy_m;
  assign ox_m = ox[31:0];
  assign oy_m = oy[31:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      {px_in, py_in, pz_in, vx, vy, vz, qx, qy, qz, qw} <= sample;
    end
    if (cmd.pred) begin
      px <= PW'(px_in) + PW'(mx >>> 8);
      py <= PW'(py_in) + PW'(my >>> 8);
      pz <= PW'(pz_in) + PW'(mz >>> 8);
    end
    if (cmd.vec_init) begin
      zero <= (num_i == '0) && (den_i == '0);
      flip <= den_i[VW-1];
      num  <= den_i[VW-1] ? -num_i : num_i;
      den  <= den_i[VW-1] ? -den_i : den_i;
    end
    if (cmd.vec_step) begin
      cw[step[$clog2(CORDIC_STEPS)-1:0]] <= ~num[VW-1];
      if (!num[VW-1]) begin
        den <= den + ns;
        num <= num - ds;
      end else begin
        den <= den - ns;
        num <= num + ds;
      end
    end
    if (cmd.rot_init) begin
      offz <= offset[15:0];
      ox <= flip ? -(RW'(offx_w) <<< 12) : (RW'(offx_w) <<< 12);
      oy <= flip ? -(RW'(offy_w) <<< 12) : (RW'(offy_w) <<< 12);
    end
    if (cmd.rot_step) begin
      if (cw[step[$clog2(CORDIC_STEPS)-1:0]]) begin
        ox <= ox - (oy >>> step);
        oy <= oy + (ox >>> step);
      end else begin
        ox <= ox + (oy >>> step);
        oy <= oy - (ox >>> step);
      end
    end
    if (cmd.gain_a) prod <= 64'(ox_m) * 64'(KINV_Q30);
    if (cmd.gain_b) begin
      rx   <= zero ? 26'(offx_w) : 26'((prod + (64'sd1 <<< 41)) >>> 42);
      prod <= 64'(oy_m) * 64'(KINV_Q30);
    end
    if (cmd.fin) begin
      ry <= zero ? 26'(offy_w) : 26'((prod + (64'sd1 <<< 41)) >>> 42);
    end
  end

  // result word: x, y, z targets
  always_comb begin
    target = {sat(px + PW'(rx)), sat(py + PW'(ry)), sat(pz + PW'(offz))};
  end
endmodule

FILE: design/fsg_ctrl.sv
// ----------------------------------------------------------------------------
// fsg_ctrl
// Sequencer: prediction and vectoring, then per follower offset load, rotation, gain and output.
// ----------------------------------------------------------------------------
module fsg_ctrl #(
  parameter int FOLLOWERS    = 5,
  parameter int CORDIC_STEPS = 16,
  parameter int FIDX_W       = 3,
  parameter int STEP_W       = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output fsg_pkg::fsg_cmd_t  cmd,
  output logic [STEP_W-1:0]  step,
  output logic [FIDX_W-1:0]  fidx,
  output logic               last
);
  import fsg_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_PRED = 4'd1, S_VEC = 4'd2,
                         S_RINIT = 4'd3, S_ROT = 4'd4, S_GA = 4'd5,
                         S_GB = 4'd6, S_FIN = 4'd7, S_OUT = 4'd8;

  logic [3:0] state;
  logic [STEP_W-1:0] step_last;
  assign step_last = STEP_W'(CORDIC_STEPS - 1);

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign last      = (fidx == FIDX_W'(FOLLOWERS - 1));

  always_comb begin
    cmd = '0;
    cmd.load     = in_valid && in_ready;
    cmd.pred     = (state == S_PRED);
    cmd.vec_init = (state == S_PRED);
    cmd.vec_step = (state == S_VEC);
    cmd.rot_init = (state == S_RINIT);
    cmd.rot_step = (state == S_ROT);
    cmd.gain_a   = (state == S_GA);
    cmd.gain_b   = (state == S_GB);
    cmd.fin      = (state == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      fidx  <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          state <= S_PRED;
        end
        S_PRED: begin
          step  <= '0;
          state <= S_VEC;
        end
        S_VEC: begin
          step <= step + 1'b1;
          if (step == step_last) begin
            fidx  <= '0;
            state <= S_RINIT;
          end
        end
        S_RINIT: begin
          step  <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          step <= step + 1'b1;
          if (step == step_last) state <= S_GA;
        end
        S_GA:  state <= S_GB;
        S_GB:  state <= S_FIN;
        S_FIN: state <= S_OUT;
        S_OUT: if (out_ready) begin
          if (last) begin
            state <= S_IDLE;
          end else begin
            fidx  <= fidx + 1'b1;
            state <= S_RINIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: design/formation_setpoint_generator.sv
// ----------------------------------------------------------------------------
// formation_setpoint_generator
// Leader-follower formation targets from one leader pose sample.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one leader sample request: position, velocity, quaternion.
//   out_ch returns FOLLOWERS target requests in follower order, is_last on
//   the final one. cfg_ch writes lookahead (index 0) and offsets (1..5).
//   After acceptance the block runs one prediction step and CORDIC_STEPS
//   yaw vectoring iterations; then per follower one offset load,
//   CORDIC_STEPS rotation iterations on the shared CORDIC unit and three
//   gain/format steps before the target is offered until taken. One sample
//   is in work at a time, so in_ch is ready only while the block is idle,
//   which it reenters once the last target is taken.
//   A stalled receiver holds the current target; work resumes once taken.
//   Reset (rst, synchronous) restores the default lookahead and offsets and
//   returns the sequencer to idle.
// ----------------------------------------------------------------------------
module formation_setpoint_generator #(
  parameter int FOLLOWERS    = fsg_pkg::FOLLOWERS_DEF,
  parameter int CORDIC_STEPS = fsg_pkg::CORDIC_STEPS_DEF
) (
  input logic clk,
  input logic rst,
  fsg_if.sink   in_ch,
  fsg_if.source out_ch,
  fsg_if.sink   cfg_ch
);
  import fsg_pkg::*;

  localparam int FIDX_W = 3;
  localparam int STEP_W = $clog2(CORDIC_STEPS) + 1;
  localparam int NREG = (FOLLOWERS < OFFSET_REGS) ? FOLLOWERS : OFFSET_REGS;

  fsg_cmd_t cmd;
  logic [STEP_W-1:0] step;
  logic [FIDX_W-1:0] fidx;
  logic last;
  logic [LA_W-1:0] lookahead;
  logic [OFS_W-1:0] offs [NREG];
  logic [OFS_W-1:0] offset;
  logic [71:0] target;
  logic [CFG_IDX_W-1:0] cidx;
  logic [OFS_W-1:0] cval;

  assign {cidx, cval} = cfg_ch.data;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lookahead <= LOOKAHEAD_RESET;
      for (int i = 0; i < NREG; i++) offs[i] <= offset_reset(i);
    end else if (cfg_ch.valid) begin
      if (cidx == REG_LOOKAHEAD) lookahead <= cval[LA_W-1:0];
      for (int i = 0; i < NREG; i++) begin
        if (cidx == CFG_IDX_W'(i + 1)) offs[i] <= cval;
      end
    end
  end

  always_comb begin
    offset = '0;
    for (int i = 0; i < NREG; i++) begin
      if (fidx == FIDX_W'(i)) offset = offs[i];
    end
  end

  fsg_ctrl #(.FOLLOWERS(FOLLOWERS), .CORDIC_STEPS(CORDIC_STEPS),
             .FIDX_W(FIDX_W), .STEP_W(STEP_W)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .step(step), .fidx(fidx), .last(last)
  );

  fsg_datapath #(.CORDIC_STEPS(CORDIC_STEPS), .STEP_W(STEP_W)) u_dp (
    .clk(clk), .cmd(cmd), .step(step),
    .sample(in_ch.data), .lookahead(lookahead), .offset(offset),
    .target(target)
  );

  assign out_ch.data = {fidx, target, last};
endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the formation setpoint generator: leader samples
// go in with bursty timing, targets come out under a shifting stall pattern,
// and every target is checked against an in-bench bit-exact predictor.
// ----------------------------------------------------------------------------
module testbench;
  import fsg_pkg::*;

  localparam int IN_W  = 6 * POS_W + 4 * QUAT_W;
  localparam int OUT_W = 3 + 3 * POS_W + 1;
  localparam int CFG_W = CFG_IDX_W + OFS_W;
  localparam int NUM_FOLLOWERS = FOLLOWERS_DEF;
  localparam int NUM_STEPS     = CORDIC_STEPS_DEF;
  localparam int SETTLE_CYCLES = 200;
  localparam int IDLE_LIMIT    = 40000;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B     = 3'd7;

  typedef struct {
    logic [POS_W-1:0]  px, py, pz, vx, vy, vz;
    logic [QUAT_W-1:0] qx, qy, qz, qw;
  } sample_t;

  typedef struct {
    logic [2:0]       idx;
    logic [POS_W-1:0] tx, ty, tz;
    logic             last;
  } target_t;

  logic clk;
  logic rst;

  fsg_if #(IN_W)  in_if  (clk);
  fsg_if #(OUT_W) out_if (clk);
  fsg_if #(CFG_W) cfg_if (clk);

  formation_setpoint_generator uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  logic [LA_W-1:0]  lookahead;
  logic [OFS_W-1:0] offsets [NUM_FOLLOWERS];
  target_t          targets_due [$];
  int               fail_count;
  int               burst_left;
  int               idle_cycles;
  int               ready_pct;
  int               pattern_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [POS_W-1:0] sat_target(input longint v);
    if (v > longint'(TGT_MAX)) return TGT_MAX;
    if (v < longint'(TGT_MIN)) return TGT_MIN;
    return v[POS_W-1:0];
  endfunction

  function automatic longint predict_shift(input longint v, input logic [LA_W-1:0] t);
    longint p;
    p = v * longint'({1'b0, t}) + 128;
    return p >>> 8;
  endfunction

  function automatic void predict_targets(input logic [IN_W-1:0] d);
    longint px, py, pz, qx, qy, qz, qw, num, den, ns, ds;
    longint ox, oy, xs, ys, rx, ry, offx, offy, offz;
    logic [NUM_STEPS-1:0] cw;
    logic degenerate, flip;
    sample_t s;
    target_t t;
    {s.px, s.py, s.pz, s.vx, s.vy, s.vz, s.qx, s.qy, s.qz, s.qw} = d;
    px = longint'($signed(s.px)) + predict_shift(longint'($signed(s.vx)), lookahead);
    py = longint'($signed(s.py)) + predict_shift(longint'($signed(s.vy)), lookahead);
    pz = longint'($signed(s.pz)) + predict_shift(longint'($signed(s.vz)), lookahead);
    qx = longint'($signed(s.qx));
    qy = longint'($signed(s.qy));
    qz = longint'($signed(s.qz));
    qw = longint'($signed(s.qw));
    num = 2 * (qw * qz + qx * qy);
    den = (longint'(1) <<< 28) - 2 * (qy * qy + qz * qz);
    degenerate = (num == 0) && (den == 0);
    flip = den < 0;
    if (flip) begin
      num = -num;
      den = -den;
    end
    cw = '0;
    for (int i = 0; i < NUM_STEPS; i++) begin
      ns = num >>> i;
      ds = den >>> i;
      if (num >= 0) begin
        den += ns;
        num -= ds;
        cw[i] = 1'b1;
      end else begin
        den -= ns;
        num += ds;
      end
    end
    for (int f = 0; f < NUM_FOLLOWERS; f++) begin
      offx = longint'($signed(offsets[f][47:32]));
      offy = longint'($signed(offsets[f][31:16]));
      offz = longint'($signed(offsets[f][15:0]));
      if (degenerate) begin
        rx = offx;
        ry = offy;
      end else begin
        ox = offx * 4096;
        oy = offy * 4096;
        if (flip) begin
          ox = -ox;
          oy = -oy;
        end
        for (int i = 0; i < NUM_STEPS; i++) begin
          xs = ox >>> i;
          ys = oy >>> i;
          if (cw[i]) begin
            ox -= ys;
            oy += xs;
          end else begin
            ox += ys;
            oy -= xs;
          end
        end
        rx = (ox * longint'(KINV_Q30) + (longint'(1) <<< 41)) >>> 42;
        ry = (oy * longint'(KINV_Q30) + (longint'(1) <<< 41)) >>> 42;
      end
      t.idx  = f[2:0];
      t.tx   = sat_target(px + rx);
      t.ty   = sat_target(py + ry);
      t.tz   = sat_target(pz + offz);
      t.last = (f == NUM_FOLLOWERS - 1);
      targets_due.push_back(t);
    end
  endfunction

  // predictor, register copy and target checker all sample at the edge
  always @(posedge clk) begin
    target_t got, want;
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.data[CFG_W-1 -: CFG_IDX_W] == REG_LOOKAHEAD)
          lookahead <= cfg_if.data[LA_W-1:0];
        else if (cfg_if.data[CFG_W-1 -: CFG_IDX_W] <= OFFSET_REGS)
          offsets[cfg_if.data[CFG_W-1 -: CFG_IDX_W] - REG_OFFSET_BASE] <= cfg_if.data[OFS_W-1:0];
      end
      if (in_if.valid && in_if.ready)
        predict_targets(in_if.data);
      if (out_if.valid && out_if.ready) begin
        {got.idx, got.tx, got.ty, got.tz, got.last} = out_if.data;
        if (targets_due.size() == 0) begin
          $error("unexpected target request idx=%0d", got.idx);
          fail_count++;
        end else begin
          want = targets_due.pop_front();
          if (got.idx !== want.idx) begin
            $error("follower_index expected %0d actual %0d", want.idx, got.idx);
            fail_count++;
          end
          if (got.tx !== want.tx) begin
            $error("target_x expected %h actual %h", want.tx, got.tx);
            fail_count++;
          end
          if (got.ty !== want.ty) begin
            $error("target_y expected %h actual %h", want.ty, got.ty);
            fail_count++;
          end
          if (got.tz !== want.tz) begin
            $error("target_z expected %h actual %h", want.tz, got.tz);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $error("is_last expected %0d actual %0d", want.last, got.last);
            fail_count++;
          end
        end
      end
    end
  end

  // receiver stall pattern: phases of no, moderate and heavy back-pressure
  always @(posedge clk) begin
    if (pattern_left == 0) begin
      case ($urandom_range(0, 2))
        0: ready_pct <= 100;
        1: ready_pct <= 70;
        default: ready_pct <= 25;
      endcase
      pattern_left <= $urandom_range(50, 400);
    end else begin
      pattern_left <= pattern_left - 1;
    end
    out_if.ready <= ($urandom_range(0, 99) < ready_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(input sample_t s);
    int gap;
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data  <= {s.px, s.py, s.pz, s.vx, s.vy, s.vz, s.qx, s.qy, s.qz, s.qw};
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    burst_left = 0;
    // let the checker record the last accepted sample first
    @(posedge clk);
    while (targets_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OFS_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= {idx, val};
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic sample_t make_sample(input int pos, input int vel,
                                          input int x, input int y, input int z, input int w);
    sample_t s;
    s.px = POS_W'(pos); s.py = POS_W'(-pos); s.pz = POS_W'(pos);
    s.vx = POS_W'(vel); s.vy = POS_W'(vel); s.vz = POS_W'(-vel);
    s.qx = QUAT_W'(x); s.qy = QUAT_W'(y); s.qz = QUAT_W'(z); s.qw = QUAT_W'(w);
    return s;
  endfunction

  function automatic logic [POS_W-1:0] rand_pos(input bit wide);
    if (wide) return POS_W'($urandom_range(0, 24'hFFFFFF));
    return POS_W'($urandom_range(0, 200000) - 100000);
  endfunction

  function automatic logic [QUAT_W-1:0] rand_quat();
    return QUAT_W'($urandom_range(0, 32768) - 16384);
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    bit wide;
    wide = ($urandom_range(0, 3) == 0);
    s.px = rand_pos(wide); s.py = rand_pos(wide); s.pz = rand_pos(wide);
    s.vx = rand_pos(wide); s.vy = rand_pos(wide); s.vz = rand_pos(wide);
    s.qx = rand_quat(); s.qy = rand_quat(); s.qz = rand_quat(); s.qw = rand_quat();
    return s;
  endfunction

  function automatic logic [OFS_W-1:0] rand_offset();
    if ($urandom_range(0, 1)) return OFS_W'({$urandom(), $urandom()});
    return {16'($urandom_range(0, 8192) - 4096), 16'($urandom_range(0, 8192) - 4096),
            16'($urandom_range(0, 2048) - 1024)};
  endfunction

  task automatic test_default_registers();
    send_sample(make_sample(0, 0, 0, 0, 0, 16384));
    send_sample(make_sample(1000, 256, 0, 0, 11585, 11585));
    send_sample(make_sample(-5000, -512, 0, 0, 16384, 0));
    send_sample(make_sample(8388607, 8388607, 0, 0, 0, 16384));
    send_sample(make_sample(-8388608, -8388608, 0, 0, 0, 16384));
    // degenerate orientation: num and den both zero
    send_sample(make_sample(300, 10, 0, 8192, 8192, 0));
    // den negative: rotation by pi
    send_sample(make_sample(300, 10, 0, 16384, 16384, 0));
    // out-of-range quaternion components
    send_sample(make_sample(77, -3, 16384, 16384, 16384, 16384));
    send_sample(make_sample(77, -3, -16384, -16384, -16384, -16384));
    send_sample(make_sample(-1, 1, -16384, 16384, -16384, 16384));
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_LOOKAHEAD, '0);
    for (int f = 0; f < NUM_FOLLOWERS; f++)
      write_reg(REG_OFFSET_BASE + f[CFG_IDX_W-1:0], {16'h7FFF, 16'h8000, 16'h7FFF});
    // indexes beyond the offsets are ignored
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '1);
    send_sample(make_sample(8388607, 8388607, 0, 0, 0, 16384));
    send_sample(make_sample(-8388608, 8388607, 0, 0, 11585, 11585));
    send_sample(make_sample(0, 0, 8192, 0, 0, 0));
    wait_drained();
    write_reg(REG_LOOKAHEAD, '1);
    for (int f = 0; f < NUM_FOLLOWERS; f++)
      write_reg(REG_OFFSET_BASE + f[CFG_IDX_W-1:0], {16'h8000, 16'h7FFF, 16'h8000});
    send_sample(make_sample(8388607, 8388607, 0, 0, 0, 16384));
    send_sample(make_sample(-8388608, -8388608, 0, 0, -16384, 0));
    send_sample(make_sample(12345, -6789, 0, 8192, 8192, 0));
    send_sample(make_sample(0, 100, 16384, 16384, 16384, 16384));
    wait_drained();
  endtask

  task automatic test_random_samples();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_reg(REG_LOOKAHEAD, OFS_W'(LOOKAHEAD_RESET));
        1: write_reg(REG_LOOKAHEAD, '1);
        2: write_reg(REG_LOOKAHEAD, '0);
        default: write_reg(REG_LOOKAHEAD, OFS_W'($urandom_range(0, 4095)));
      endcase
      for (int f = 0; f < NUM_FOLLOWERS; f++)
        write_reg(REG_OFFSET_BASE + f[CFG_IDX_W-1:0], rand_offset());
      for (int n = 0; n < 56; n++) begin
        send_sample(rand_sample());
        // hold off until all targets are back
        if (n == 28) begin
          in_if.valid <= 1'b0;
          burst_left = 0;
          @(posedge clk);
          while (targets_due.size() != 0) @(posedge clk);
        end
      end
      wait_drained();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    ready_pct = 100;
    pattern_left = 0;
    idle_cycles = 0;
    fail_count = 0;
    burst_left = 0;
    lookahead = LOOKAHEAD_RESET;
    for (int f = 0; f < NUM_FOLLOWERS; f++)
      offsets[f] = offset_reset(f);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_registers();
    test_register_extremes();
    test_random_samples();
    wait_drained();
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
